// ===== src/tasc_pkg.sv =====
// Package for the tilt-angle step counter: widths, CORDIC constants,
// arctangent table and the sequencer-to-lane control struct.
// No dependencies.
`default_nettype none

package tasc_pkg;

  // Word field widths
  localparam int ACCEL_W = 16;
  localparam int ANGLE_W = 16;
  localparam int STEPS_W = 32;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_THRESHOLD = CFG_ADDR_W'(0);
  localparam logic [ANGLE_W-1:0] THRESH_RESET = ANGLE_W'(256);

  // CORDIC
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < ATAN_TABLE_LEN) ?
                                CORDIC_ITERATIONS : ATAN_TABLE_LEN;
  localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int TABLE_IDX_W = $clog2(ATAN_TABLE_LEN);

  // Datapath word: 17-bit magnitude, gain headroom, 16 fraction bits, sign
  localparam int FRAC_W = 16;
  localparam int DATA_W = 36;
  localparam int DIGIT_W = 12;
  localparam int NUM_DIGITS = DATA_W / DIGIT_W;
  localparam int DIGIT_IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int BIT_IDX_W = $clog2(DATA_W);

  // Angle accumulator: degrees * 2^16, two's complement
  localparam int ACC_W = 26;
  localparam int DEG_HALF = 180 * 65536;
  localparam int DEG_FULL = 360 * 65536;
  localparam int ROUND_HALF = 256;
  localparam int CONV_SHIFT = 9;
  localparam int CONV_W = ACC_W - CONV_SHIFT;
  localparam int FULL_TURN = 46080;

  // atan(2^-i) in degrees * 2^16, rounded to nearest
  localparam logic [ACC_W-1:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
    ACC_W'(2949120), ACC_W'(1740967), ACC_W'(919879), ACC_W'(466945),
    ACC_W'(234379),  ACC_W'(117304),  ACC_W'(58666),  ACC_W'(29335),
    ACC_W'(14668),   ACC_W'(7334),    ACC_W'(3667),   ACC_W'(1833),
    ACC_W'(917),     ACC_W'(458),     ACC_W'(229),    ACC_W'(115),
    ACC_W'(57),      ACC_W'(29),      ACC_W'(14),     ACC_W'(7),
    ACC_W'(4),       ACC_W'(2),       ACC_W'(1),      ACC_W'(0)
  };

  function automatic logic [ACC_W-1:0] atan_entry(input logic [TABLE_IDX_W-1:0] idx);
    return ATAN_TABLE[idx];
  endfunction

  // Sequencer control shared by both lanes
  typedef struct packed {
    logic                   load;
    logic                   run;
    logic                   first_digit;
    logic                   last_digit;
    logic                   fix;
    logic                   conv;
    logic [ITER_W-1:0]      iter;
    logic [BIT_IDX_W-1:0]   limit;   // highest bit position still holding old data
  } tasc_ctrl_t;

endpackage

`default_nettype wire

// ===== src/tasc_in_if.sv =====
// Input channel interface: one accelerometer sample word.
// Depends on tasc_pkg.
`default_nettype none

interface tasc_in_if import tasc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

`default_nettype wire

// ===== src/tasc_out_if.sv =====
// Result channel interface: two tilt angles and the step count.
// Depends on tasc_pkg.
`default_nettype none

interface tasc_out_if import tasc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] tilt_xz;
  logic [ANGLE_W-1:0] tilt_yz;
  logic               step_taken;
  logic [STEPS_W-1:0] steps;

  modport source (output valid, output tilt_xz, output tilt_yz,
                  output step_taken, output steps, input ready);
  modport sink   (input valid, input tilt_xz, input tilt_yz,
                  input step_taken, input steps, output ready);
endinterface

`default_nettype wire

// ===== src/tasc_seq.sv =====
// Sequencer: walks digits and CORDIC iterations, then finish and commit.
// Depends on tasc_pkg.
`default_nettype none

module tasc_seq import tasc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic out_free,
  output logic      in_ready,
  output logic      commit,
  output tasc_ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_CONV = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;

  localparam logic [BIT_IDX_W-1:0] LIMIT_TOP = BIT_IDX_W'(DATA_W - 1);

  logic [2:0]             state_r, state_nxt;
  logic [DIGIT_IDX_W-1:0] digit_r, digit_nxt;
  logic [ITER_W-1:0]      iter_r, iter_nxt;
  logic [BIT_IDX_W-1:0]   limit_r, limit_nxt;
  logic                   last_digit;
  logic                   load;

  assign last_digit = (digit_r == DIGIT_IDX_W'(NUM_DIGITS - 1));

  always_comb begin
    state_nxt = state_r;
    digit_nxt = digit_r;
    iter_nxt  = iter_r;
    limit_nxt = limit_r;
    in_ready  = 1'b0;
    commit    = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load      = 1'b1;
          state_nxt = S_RUN;
          digit_nxt = '0;
          iter_nxt  = '0;
          limit_nxt = LIMIT_TOP;
        end
      end
      S_RUN: begin
        if (last_digit) begin
          digit_nxt = '0;
          limit_nxt = LIMIT_TOP;
          iter_nxt  = iter_r + ITER_W'(1);
          if (iter_r == ITER_W'(CORDIC_STEPS - 1)) begin
            state_nxt = S_FIX;
          end
        end else begin
          digit_nxt = digit_r + DIGIT_IDX_W'(1);
          limit_nxt = limit_r - BIT_IDX_W'(DIGIT_W);
        end
      end
      S_FIX:  state_nxt = S_CONV;
      S_CONV: state_nxt = S_EVAL;
      S_EVAL: begin
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      digit_r <= '0;
      iter_r  <= '0;
      limit_r <= LIMIT_TOP;
    end else begin
      state_r <= state_nxt;
      digit_r <= digit_nxt;
      iter_r  <= iter_nxt;
      limit_r <= limit_nxt;
    end
  end

  always_comb begin
    ctrl.load        = load;
    ctrl.run         = (state_r == S_RUN);
    ctrl.first_digit = (digit_r == '0);
    ctrl.last_digit  = last_digit;
    ctrl.fix         = (state_r == S_FIX);
    ctrl.conv        = (state_r == S_CONV);
    ctrl.iter        = iter_r;
    ctrl.limit       = limit_r;
  end

endmodule

`default_nettype wire

// ===== src/tasc_cordic_lane.sv =====
// Digit-serial vectoring CORDIC lane: atan2(b, a) in 1/128 degree.
// Depends on tasc_pkg; driven by tasc_seq control.
`default_nettype none

module tasc_cordic_lane import tasc_pkg::*; (
  input  wire logic                      clk,
  input  wire tasc_ctrl_t                ctrl,
  input  wire logic signed [ACCEL_W-1:0] accel_a,
  input  wire logic signed [ACCEL_W-1:0] accel_b,
  output logic [ANGLE_W-1:0]             angle
);

  localparam int EXT_W = DATA_W - (ACCEL_W + 1) - FRAC_W;

  // x and y rotate right one digit per cycle while running; new digits enter at the top
  logic [DATA_W-1:0]    x_r, y_r;
  logic                 xs_r, ys_r;     // signs at start of the iteration
  logic                 cx_r, cy_r;     // digit carries
  logic [ACC_W-1:0]     acc_r;
  logic                 zero_r;
  logic [ANGLE_W-1:0]   angle_r;

  logic                 a_neg;
  logic [ACCEL_W:0]     a_ext, b_ext, vx, vy;
  logic                 dir;            // 1: y >= 0, rotate clockwise
  logic [DIGIT_W-1:0]   xsh, ysh;       // digit of x >> i and y >> i
  logic [DIGIT_W-1:0]   xadd, yadd;
  logic                 cin_x, cin_y;
  logic [DIGIT_W:0]     sum_x, sum_y;
  logic [ACC_W-1:0]     tab;
  logic [ACC_W-1:0]     rnd;
  logic [CONV_W-1:0]    conv_raw, conv_wrap;

  assign a_neg = accel_a[ACCEL_W-1];
  assign a_ext = {accel_a[ACCEL_W-1], accel_a};
  assign b_ext = {accel_b[ACCEL_W-1], accel_b};
  assign vx    = a_neg ? (~a_ext + (ACCEL_W+1)'(1)) : a_ext;
  assign vy    = a_neg ? (~b_ext + (ACCEL_W+1)'(1)) : b_ext;

  assign dir = ~ys_r;

  // Shifted operand digits, sign-extended past the untouched part
  always_comb begin
    logic [BIT_IDX_W-1:0] p;
    p = '0;
    for (int t = 0; t < DIGIT_W; t++) begin
      p = BIT_IDX_W'(t) + BIT_IDX_W'(ctrl.iter);
      xsh[t] = (p <= ctrl.limit) ? x_r[p] : xs_r;
      ysh[t] = (p <= ctrl.limit) ? y_r[p] : ys_r;
    end
  end

  assign xadd  = dir ? ysh : ~ysh;
  assign yadd  = dir ? ~xsh : xsh;
  assign cin_x = ctrl.first_digit ? ~dir : cx_r;
  assign cin_y = ctrl.first_digit ? dir : cy_r;
  assign sum_x = {1'b0, x_r[DIGIT_W-1:0]} + {1'b0, xadd} + (DIGIT_W+1)'(cin_x);
  assign sum_y = {1'b0, y_r[DIGIT_W-1:0]} + {1'b0, yadd} + (DIGIT_W+1)'(cin_y);

  assign tab = atan_entry(TABLE_IDX_W'(ctrl.iter));

  // Final scaling to 1/128 degree with full-turn fold
  assign rnd       = acc_r + ACC_W'(ROUND_HALF);
  assign conv_raw  = rnd[ACC_W-1:CONV_SHIFT];
  assign conv_wrap = (conv_raw >= CONV_W'(FULL_TURN)) ?
                     (conv_raw - CONV_W'(FULL_TURN)) : conv_raw;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r    <= {{EXT_W{vx[ACCEL_W]}}, vx, {FRAC_W{1'b0}}};
      y_r    <= {{EXT_W{vy[ACCEL_W]}}, vy, {FRAC_W{1'b0}}};
      xs_r   <= vx[ACCEL_W];
      ys_r   <= vy[ACCEL_W];
      cx_r   <= 1'b0;
      cy_r   <= 1'b0;
      acc_r  <= a_neg ? ACC_W'(DEG_HALF) : '0;
      zero_r <= (accel_a == '0) && (accel_b == '0);
    end else if (ctrl.run) begin
      x_r  <= {sum_x[DIGIT_W-1:0], x_r[DATA_W-1:DIGIT_W]};
      y_r  <= {sum_y[DIGIT_W-1:0], y_r[DATA_W-1:DIGIT_W]};
      cx_r <= sum_x[DIGIT_W];
      cy_r <= sum_y[DIGIT_W];
      if (ctrl.last_digit) begin
        xs_r  <= sum_x[DIGIT_W-1];
        ys_r  <= sum_y[DIGIT_W-1];
        acc_r <= dir ? (acc_r + tab) : (acc_r - tab);
      end
    end else if (ctrl.fix) begin
      if (acc_r[ACC_W-1]) begin
        acc_r <= acc_r + ACC_W'(DEG_FULL);
      end
    end else if (ctrl.conv) begin
      angle_r <= zero_r ? '0 : ANGLE_W'(conv_wrap);
    end
  end

  assign angle = angle_r;

endmodule

`default_nettype wire

// ===== src/tasc_step.sv =====
// Step decision: compares both angles against the stored reference,
// keeps the reference angles and the wrapping step total. Depends on tasc_pkg.
`default_nettype none

module tasc_step import tasc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [ANGLE_W-1:0] tilt_xz,
  input  wire logic [ANGLE_W-1:0] tilt_yz,
  input  wire logic [ANGLE_W-1:0] thresh,
  input  wire logic               commit,
  output logic                    step,
  output logic [STEPS_W-1:0]      steps_after
);

  logic [ANGLE_W-1:0] ref_xz_r, ref_yz_r;
  logic [STEPS_W-1:0] total_r;
  logic [ANGLE_W-1:0] diff_xz, diff_yz;

  function automatic logic [ANGLE_W-1:0] abs_diff(input logic [ANGLE_W-1:0] p,
                                                  input logic [ANGLE_W-1:0] q);
    return (p > q) ? (p - q) : (q - p);
  endfunction

  assign diff_xz     = abs_diff(tilt_xz, ref_xz_r);
  assign diff_yz     = abs_diff(tilt_yz, ref_yz_r);
  assign step        = (diff_xz > thresh) && (diff_yz > thresh);
  assign steps_after = step ? (total_r + STEPS_W'(1)) : total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_xz_r <= '0;
      ref_yz_r <= '0;
      total_r  <= '0;
    end else if (commit && step) begin
      ref_xz_r <= tilt_xz;
      ref_yz_r <= tilt_yz;
      total_r  <= steps_after;
    end
  end

endmodule

`default_nettype wire

// ===== src/tilt_angle_step_counter_top.sv =====
// Top level of the tilt-angle step counter: APB threshold register,
// sequencer, two CORDIC lanes, step unit and output register.
// Depends on tasc_pkg, tasc_in_if, tasc_out_if, tasc_seq, tasc_cordic_lane, tasc_step.
// Each word goes through accept, 16 iterations x 3 digits, fix, convert and commit;
// a new word is taken only after commit, and commit waits for a free output register.
// The pace is set by the 12-bit digit-serial CORDIC datapath, 3 digits per iteration.
// A finished word waits in the output register while the next sample is taken.
// Reset (rst_n low, synchronous) clears sequencer, output valid, reference angles,
// step total and sets the threshold to 256.
`default_nettype none

module tilt_angle_step_counter_top import tasc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tasc_in_if.sink                    in_ch,
  tasc_out_if.source                 out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  tasc_ctrl_t         ctrl;
  logic               commit;
  logic               out_free;
  logic [ANGLE_W-1:0] thresh_r;
  logic               cfg_wr;
  logic [ANGLE_W-1:0] tilt_xz, tilt_yz;
  logic               step;
  logic [STEPS_W-1:0] steps_after;

  logic               out_valid_r;
  logic [ANGLE_W-1:0] out_xz_r, out_yz_r;
  logic               out_step_r;
  logic [STEPS_W-1:0] out_steps_r;

  // ---- configuration port: single threshold register at offset 0
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == CFG_ADDR_THRESHOLD);
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_THRESHOLD) ? CFG_DATA_W'(thresh_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr) begin
      thresh_r <= cfg_pwdata[ANGLE_W-1:0];
    end
  end

  // ---- control: one sample in flight; commit waits for a free output register
  assign out_free = !out_valid_r || out_ch.ready;

  tasc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .in_ready (in_ch.ready),
    .commit   (commit),
    .ctrl     (ctrl)
  );

  // ---- two lanes share the sequencer: atan2(z,x) and atan2(z,y)
  tasc_cordic_lane u_lane_xz (
    .clk     (clk),
    .ctrl    (ctrl),
    .accel_a (in_ch.accel_x),
    .accel_b (in_ch.accel_z),
    .angle   (tilt_xz)
  );

  tasc_cordic_lane u_lane_yz (
    .clk     (clk),
    .ctrl    (ctrl),
    .accel_a (in_ch.accel_y),
    .accel_b (in_ch.accel_z),
    .angle   (tilt_yz)
  );

  // ---- step decision and reference update on commit
  tasc_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .tilt_xz     (tilt_xz),
    .tilt_yz     (tilt_yz),
    .thresh      (thresh_r),
    .commit      (commit),
    .step        (step),
    .steps_after (steps_after)
  );

  // ---- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_xz_r    <= tilt_xz;
      out_yz_r    <= tilt_yz;
      out_step_r  <= step;
      out_steps_r <= steps_after;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tilt_xz    = out_xz_r;
  assign out_ch.tilt_yz    = out_yz_r;
  assign out_ch.step_taken = out_step_r;
  assign out_ch.steps      = out_steps_r;

endmodule

`default_nettype wire

// ===== src/tasc_checker.sv =====
// Port-level checks for the tilt-angle step counter, bound to the top level.
// Depends on tasc_pkg and tilt_angle_step_counter_top.
`default_nettype none

module tasc_checker import tasc_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [ANGLE_W-1:0] tilt_xz,
  input wire logic [ANGLE_W-1:0] tilt_yz,
  input wire logic               step_taken,
  input wire logic [STEPS_W-1:0] steps
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid not cleared by reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tilt_xz) &&
      $stable(tilt_yz) && $stable(step_taken) && $stable(steps))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while one is in flight");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (tilt_xz < ANGLE_W'(FULL_TURN)) && (tilt_yz < ANGLE_W'(FULL_TURN)))
    else $error("angle outside full turn");

endmodule

bind tilt_angle_step_counter_top tasc_checker u_tasc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .tilt_xz    (out_ch.tilt_xz),
  .tilt_yz    (out_ch.tilt_yz),
  .step_taken (out_ch.step_taken),
  .steps      (out_ch.steps)
);

`default_nettype wire

// ===== tb/sv/tilt_angle_step_counter_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the tilt-angle step counter: sends accelerometer words, predicts
// both tilt angles and the step count in its own CORDIC model, checks every result.
// Depends on tasc_pkg, tasc_in_if, tasc_out_if and tilt_angle_step_counter_top.

module tilt_angle_step_counter_top_tb;
  import tasc_pkg::*;

  // Predictor settings: CORDIC length, accumulator scale, angle wrap point
  localparam int     TILT_ITERS     = 16;
  localparam int     TILT_TABLE_LEN = 24;
  localparam longint DEG_UNIT       = 65536;
  localparam longint ANGLE_WRAP     = 46080;
  localparam int     ROUND_ADD      = 256;
  localparam int     TO_ANGLE_SHIFT = 9;

  localparam int     MAX_IDLE       = 16;
  localparam int     RESET_CYCLES   = 6;
  localparam int     RANDOM_ITEMS   = 2000;
  localparam int     NUM_PHASES     = 12;
  localparam int     HOLD_CYCLES    = 400;  // long output hold-off
  localparam int     TAIL_CYCLES    = 80;   // longer than one word's latency
  localparam int     PRINT_CAP      = 30;

  typedef struct {
    logic signed [ACCEL_W-1:0] x;
    logic signed [ACCEL_W-1:0] y;
    logic signed [ACCEL_W-1:0] z;
  } sample_t;

  typedef struct {
    logic [ANGLE_W-1:0] tilt_xz;
    logic [ANGLE_W-1:0] tilt_yz;
    logic               step_taken;
    logic [STEPS_W-1:0] steps;
  } tilt_word_t;

  // atan(2^-i) in degrees * 2^16
  longint atan_deg [TILT_TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tasc_in_if  in_ch ();
  tasc_out_if out_ch ();

  tilt_angle_step_counter_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Predictor state: mirrors the block's register and reference angles
  logic [ANGLE_W-1:0] thresh_model;
  logic [ANGLE_W-1:0] ref_xz;
  logic [ANGLE_W-1:0] ref_yz;
  logic [STEPS_W-1:0] step_tally;

  // Words waiting to be sent (head is the one on the bus) and results owed
  sample_t    sample_q[$];
  tilt_word_t expected_words[$];

  // Idle switches and the pending output hold-off
  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;
  int hold_req    = 0;

  int errors        = 0;
  int words_checked = 0;
  int steps_seen    = 0;
  int thresh_writes = 0;
  int longest_hold  = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // atan2(b, a) in 1/128 degree via vectoring CORDIC, 0 .. 46079
  function automatic logic [ANGLE_W-1:0] tilt_angle_of(input longint a, input longint b);
    longint vx, vy, acc, dx, dy, conv;
    if (a == 0 && b == 0) return '0;
    vx  = a;
    vy  = b;
    acc = 0;
    // left half-plane: fold over and start at 180 degrees
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      acc = 180 * DEG_UNIT;
    end
    vx = vx * DEG_UNIT;
    vy = vy * DEG_UNIT;
    for (int i = 0; i < TILT_ITERS && i < TILT_TABLE_LEN; i++) begin
      dx = vy >>> i;   // floor shift
      dy = vx >>> i;
      if (vy >= 0) begin
        vx  += dx;
        vy  -= dy;
        acc += atan_deg[i];
      end else begin
        vx  -= dx;
        vy  += dy;
        acc -= atan_deg[i];
      end
    end
    if (acc < 0) acc += 360 * DEG_UNIT;
    conv = (acc + ROUND_ADD) >>> TO_ANGLE_SHIFT;
    // rounding up to a full turn reads as zero
    if (conv >= ANGLE_WRAP) conv -= ANGLE_WRAP;
    return conv[ANGLE_W-1:0];
  endfunction

  // Angles plus step decision for one accepted word; updates the references
  function automatic tilt_word_t predict_tilt_word(input sample_t s);
    tilt_word_t         w;
    logic [ANGLE_W-1:0] dxz, dyz;
    w.tilt_xz = tilt_angle_of(s.x, s.z);
    w.tilt_yz = tilt_angle_of(s.y, s.z);
    dxz = (w.tilt_xz > ref_xz) ? w.tilt_xz - ref_xz : ref_xz - w.tilt_xz;
    dyz = (w.tilt_yz > ref_yz) ? w.tilt_yz - ref_yz : ref_yz - w.tilt_yz;
    w.step_taken = (dxz > thresh_model) && (dyz > thresh_model);
    if (w.step_taken) begin
      step_tally = step_tally + 1'b1;   // wraps at 2^32
      ref_xz     = w.tilt_xz;
      ref_yz     = w.tilt_yz;
    end
    w.steps = step_tally;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers and checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch at word %0d, %s: got %0d, want %0d", words_checked, what, got, want);
  endtask

  function automatic logic signed [ACCEL_W-1:0] clamp_accel(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return ACCEL_W'(v);
  endfunction

  // Queue one word; blocks while the input is backed up
  task automatic send_sample(input logic signed [ACCEL_W-1:0] x,
                             input logic signed [ACCEL_W-1:0] y,
                             input logic signed [ACCEL_W-1:0] z);
    sample_t s;
    s.x = x;
    s.y = y;
    s.z = z;
    sample_q.push_back(s);
    while (sample_q.size() > 1) @(posedge clk);
  endtask

  // Input side: one NBA to valid per step; the word leaves the queue on accept
  task automatic drive_samples();
    int      gap;
    sample_t s;
    forever begin
      if (sample_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end else begin
        gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        s = sample_q[0];
        in_ch.valid   <= 1'b1;
        in_ch.accel_x <= s.x;
        in_ch.accel_y <= s.y;
        in_ch.accel_z <= s.z;
        do @(posedge clk); while (!in_ch.ready);
        void'(sample_q.pop_front());
        expected_words.push_back(predict_tilt_word(s));
      end
    end
  endtask

  task automatic check_word();
    tilt_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("word with nothing expected", 0, 0);
      return;
    end
    want = expected_words.pop_front();
    if (out_ch.tilt_xz !== want.tilt_xz)
      report_mismatch("tilt_xz", out_ch.tilt_xz, want.tilt_xz);
    if (out_ch.tilt_yz !== want.tilt_yz)
      report_mismatch("tilt_yz", out_ch.tilt_yz, want.tilt_yz);
    if (out_ch.step_taken !== want.step_taken)
      report_mismatch("step_taken", out_ch.step_taken, want.step_taken);
    if (out_ch.steps !== want.steps)
      report_mismatch("steps", out_ch.steps, want.steps);
    words_checked++;
    if (want.step_taken) steps_seen++;
  endtask

  // Output side: random stalls, or one long hold-off when requested
  task automatic collect_results();
    int n;
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        if (n > longest_hold) longest_hold = n;
      end else begin
        n = snk_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_word();
    end
  endtask

  // APB write; psel stays low before the task returns, so it never drops and rises in one step
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == CFG_ADDR_THRESHOLD) begin
      thresh_model = data[ANGLE_W-1:0];
      thresh_writes++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [CFG_ADDR_W-1:0] addr, output logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_threshold_readback();
    logic [CFG_DATA_W-1:0] rd;
    apb_read(CFG_ADDR_THRESHOLD, rd);
    if (rd !== CFG_DATA_W'(thresh_model))
      report_mismatch("threshold readback", rd, thresh_model);
  endtask

  // Block is idle once nothing is queued or owed
  task automatic wait_idle();
    while (sample_q.size() != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One tilt gesture: jitter around a base vector, sometimes a jump
  task automatic send_walk();
    int r, len, spread, kind;
    int bx, by, bz, x, y, z;
    kind = $urandom_range(0, 7);
    r = (kind == 0) ? 3 : (kind == 1) ? 32768 : 20000;
    bx = int'($urandom_range(0, 2 * r)) - r;
    by = int'($urandom_range(0, 2 * r)) - r;
    bz = int'($urandom_range(0, 2 * r)) - r;
    len = $urandom_range(3, 12);
    src_idle_on = ($urandom_range(0, 3) != 0);
    snk_idle_on = ($urandom_range(0, 3) != 0);
    repeat (len) begin
      kind = $urandom_range(0, 9);
      spread = (kind < 4) ? 24 : (kind < 7) ? 1500 : 9000;
      if (kind == 9) begin
        // broken gesture: an unrelated word
        send_sample(16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        x = bx + int'($urandom_range(0, 2 * spread)) - spread;
        y = by + int'($urandom_range(0, 2 * spread)) - spread;
        z = bz + int'($urandom_range(0, 2 * spread)) - spread;
        send_sample(clamp_accel(x), clamp_accel(y), clamp_accel(z));
        if ($urandom_range(0, 2) == 0) begin
          bx = x;
          by = y;
          bz = z;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_threshold();
    check_threshold_readback();
  endtask

  // Unused addresses are ignored, upper data bits are dropped
  task automatic test_register_access();
    for (int a = 0; a < (1 << CFG_ADDR_W); a++)
      if (a != CFG_ADDR_THRESHOLD) apb_write(CFG_ADDR_W'(a), $urandom);
    check_threshold_readback();
    apb_write(CFG_ADDR_THRESHOLD, 32'hffff_0100);
    check_threshold_readback();
    apb_write(CFG_ADDR_THRESHOLD, $urandom);
    check_threshold_readback();
    apb_write(CFG_ADDR_THRESHOLD, CFG_DATA_W'(THRESH_RESET));
    check_threshold_readback();
  endtask

  // Axes, quadrants, zero vector, full-circle rounding, field extremes
  task automatic test_directed_angles();
    send_sample(0, 0, 0);                  // zero vector on both lanes
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, -32768, 0);
    send_sample(-32768, 32767, -1);
    send_sample(32767, 32767, -1);         // rounds to 360, reads as 0
    send_sample(0, 0, 32767);
    send_sample(0, 0, -32768);
    send_sample(-1, -1, 0);
    send_sample(0, 5, 0);                  // zero vector on the xz lane only
    send_sample(-32768, 0, 32767);
    send_sample(1, -1, 1);
    send_sample(32767, -32768, -32768);
    send_sample(-32768, -1, 32767);
    wait_idle();
  endtask

  // Zero threshold, and thresholds that no change can exceed
  task automatic test_threshold_extremes();
    apb_write(CFG_ADDR_THRESHOLD, '0);
    check_threshold_readback();
    send_sample(0, 0, 32767);
    send_sample(0, 0, 32767);              // no change: not strictly above 0
    send_sample(32767, -32768, 1);
    wait_idle();
    apb_write(CFG_ADDR_THRESHOLD, CFG_DATA_W'(46079));
    check_threshold_readback();
    send_sample(32767, 32767, -1);
    send_sample(-32768, -32768, 32767);
    wait_idle();
    apb_write(CFG_ADDR_THRESHOLD, CFG_DATA_W'(16'hffff));
    check_threshold_readback();
    send_sample(-1, 1, -32768);
    send_sample(32767, 0, 0);
    wait_idle();
    apb_write(CFG_ADDR_THRESHOLD, CFG_DATA_W'(THRESH_RESET));
  endtask

  // Output held for a long stretch while input keeps offering words
  task automatic test_output_backpressure();
    src_idle_on = 1'b0;
    hold_req = HOLD_CYCLES;
    repeat (10) send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    wait_idle();
    src_idle_on = 1'b1;
  endtask

  // Phases over several thresholds; mostly gestures, some noise words.
  // A count wrap would need 2^32 steps and is left to the predictor's width.
  task automatic test_random_walks();
    logic [ANGLE_W-1:0] plan [NUM_PHASES] = '{
      16'd256, 16'd0, 16'd1, 16'd64, 16'd1024, 16'd4096,
      16'd8192, 16'd20000, 16'd46078, 16'd46079, 16'hffff, 16'd512
    };
    logic [ANGLE_W-1:0] thr;
    int target, start;
    target = RANDOM_ITEMS / NUM_PHASES;
    for (int p = 0; p < NUM_PHASES; p++) begin
      thr = (p == NUM_PHASES - 1) ? 16'($urandom_range(0, 3000)) : plan[p];
      // random upper bits exercise every data line
      apb_write(CFG_ADDR_THRESHOLD, {16'($urandom), thr});
      check_threshold_readback();
      start = words_checked + expected_words.size() + sample_q.size();
      while (words_checked + expected_words.size() + sample_q.size() - start < target) begin
        if ($urandom_range(0, 9) < 2) begin
          src_idle_on = ($urandom_range(0, 3) != 0);
          send_sample(16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          send_walk();
        end
      end
      wait_idle();
    end
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.accel_x <= '0;
    in_ch.accel_y <= '0;
    in_ch.accel_z <= '0;
    out_ch.ready  <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    thresh_model  = THRESH_RESET;
    ref_xz        = '0;
    ref_yz        = '0;
    step_tally    = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fork
      drive_samples();
      collect_results();
    join_none

    test_reset_threshold();
    test_register_access();
    test_directed_angles();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_walks();

    wait_idle();
    // late or extra words would show up here
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch("words never delivered", 0, expected_words.size());

    $display("summary: %0d sample words checked, %0d of them counted as steps",
             words_checked, steps_seen);
    $display("summary: %0d threshold writes, output held off up to %0d cycles",
             thresh_writes, longest_hold);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Slowest correct run is under 2 ms; this is several times that
  initial begin
    #8_000_000;
    $display("timeout: %0d words still owed", expected_words.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
src/tasc_pkg.sv
src/tasc_in_if.sv
src/tasc_out_if.sv
src/tasc_seq.sv
src/tasc_cordic_lane.sv
src/tasc_step.sv
src/tilt_angle_step_counter_top.sv
src/tasc_checker.sv
tb/sv/tilt_angle_step_counter_top_tb.sv
